>>> hw/rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// types and constants shared by the contiguous block allocator
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int MAX_BLOCKS_DEF = 1024;

  localparam int LEN_W   = 11;
  localparam int START_W = 10;
  localparam int COUNT_W = 11;

  localparam logic [LEN_W-1:0]   TOTAL_RST = 11'd1024;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef struct packed {
    logic               func;
    logic [START_W-1:0] first_block;
    logic [LEN_W-1:0]   run_length;
  } in_beat_t;

  typedef struct packed {
    logic               status;
    logic [START_W-1:0] run_start;
    logic [COUNT_W-1:0] used_count;
  } out_beat_t;

endpackage

>>> hw/rtl/cba_map_ram.sv
// ----------------------------------------------------------------------------
// cba_map_ram
// one-bit usage map, one write port and one registered read port
// ----------------------------------------------------------------------------
module cba_map_ram
  import cba_pkg::*;
#(
  parameter int DEPTH = MAX_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_data
);

  logic map_mem [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= map_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/contiguous_block_allocator_core.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator_core
// first-fit allocator of contiguous block runs over a one-bit usage map
//
//   channel   dir   handshake               payload
//   in        in    in_valid / in_stall     in_beat  (func, first_block, run_length)
//   out       out   out_valid / out_stall   out_beat (status, run_start, used_count)
//   cfg       in    cfg_we                  cfg_wdata (total_blocks)
//
// after the accept cycle:
// allocate: one map bit read per cycle from block 0 up until run_length free
//   blocks in a row or limit, then the run is marked, the count updated and
//   the result registered; a zero-length allocate goes straight to the result
// free: one map bit cleared per cycle over the run blocks below limit
// after reset the map is swept clear while in_stall is high
// in_stall is low only when no beat is in progress; the result register holds
//   a beat under out_stall and the next beat can be taken meanwhile
// ----------------------------------------------------------------------------
module contiguous_block_allocator_core
  import cba_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_beat,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_beat,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int PW    = ($clog2(MAX_BLOCKS + 1) > 12) ? $clog2(MAX_BLOCKS + 1) : 12;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE,
    S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [PW-1:0]      ptr_r, ptr_nxt;
  logic [PW-1:0]      chk_idx_r, chk_idx_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [PW-1:0]      cand_r, cand_nxt;
  logic [LEN_W-1:0]   run_r, run_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               status_r, status_nxt;
  logic [START_W-1:0] start_r, start_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [LEN_W-1:0]   total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_beat_r, out_beat_nxt;

  logic [PW-1:0]      limit;
  logic               in_acc;
  logic [COUNT_W:0]   count_sum;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_data;

  cba_map_ram #(
    .DEPTH (MAX_BLOCKS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign limit = (PW'(total_r) > PW'(MAX_BLOCKS)) ? PW'(MAX_BLOCKS) : PW'(total_r);
  assign in_stall = (state_r != S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign count_sum = {1'b0, count_r} + {1'b0, len_r};

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = chk_vld_r;
    cand_nxt      = cand_r;
    run_nxt       = run_r;
    rem_nxt       = rem_r;
    len_nxt       = len_r;
    status_nxt    = status_r;
    start_nxt     = start_r;
    count_nxt     = count_r;
    total_nxt     = cfg_we ? cfg_wdata : total_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_beat_nxt  = out_beat_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r[IDX_W-1:0];
    wr_data       = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[IDX_W-1:0];

    case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (ptr_r == PW'(MAX_BLOCKS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + PW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          len_nxt = in_beat.run_length;
          if (in_beat.func == FUNC_FREE) begin
            ptr_nxt   = PW'(in_beat.first_block);
            rem_nxt   = in_beat.run_length;
            state_nxt = S_FREE;
          end else if (in_beat.run_length == '0) begin
            status_nxt = STATUS_OK;
            start_nxt  = '0;
            state_nxt  = S_DONE;
          end else begin
            ptr_nxt     = '0;
            run_nxt     = '0;
            chk_vld_nxt = 1'b0;
            state_nxt   = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // issue the next read while the previous bit is checked
        if (ptr_r < limit) begin
          rd_en       = 1'b1;
          ptr_nxt     = ptr_r + PW'(1);
          chk_idx_nxt = ptr_r;
          chk_vld_nxt = 1'b1;
        end else begin
          chk_vld_nxt = 1'b0;
        end
        if (chk_vld_r) begin
          if (!rd_data) begin
            if (run_r == '0) begin
              cand_nxt = chk_idx_r;
            end
            run_nxt = run_r + LEN_W'(1);
            if (run_r + LEN_W'(1) == len_r) begin
              ptr_nxt     = (run_r == '0) ? chk_idx_r : cand_r;
              rem_nxt     = len_r;
              chk_vld_nxt = 1'b0;
              state_nxt   = S_MARK;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (ptr_r >= limit) begin
          status_nxt = STATUS_FAIL;
          start_nxt  = '0;
          state_nxt  = S_DONE;
        end
      end

      S_MARK: begin
        if (rem_r != '0) begin
          wr_en   = 1'b1;
          wr_data = 1'b1;
          ptr_nxt = ptr_r + PW'(1);
          rem_nxt = rem_r - LEN_W'(1);
        end else begin
          count_nxt  = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
          status_nxt = STATUS_OK;
          start_nxt  = cand_r[START_W-1:0];
          state_nxt  = S_DONE;
        end
      end

      S_FREE: begin
        if ((rem_r != '0) && (ptr_r < limit)) begin
          wr_en   = 1'b1;
          ptr_nxt = ptr_r + PW'(1);
          rem_nxt = rem_r - LEN_W'(1);
        end else begin
          count_nxt  = (count_r > len_r) ? count_r - len_r : '0;
          status_nxt = STATUS_OK;
          start_nxt  = '0;
          state_nxt  = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_beat_nxt.status     = status_r;
          out_beat_nxt.run_start  = start_r;
          out_beat_nxt.used_count = count_r;
          state_nxt               = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      ptr_r       <= '0;
      chk_vld_r   <= 1'b0;
      count_r     <= '0;
      total_r     <= TOTAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      chk_vld_r   <= chk_vld_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    chk_idx_r  <= chk_idx_nxt;
    cand_r     <= cand_nxt;
    run_r      <= run_nxt;
    rem_r      <= rem_nxt;
    len_r      <= len_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

endmodule
